// ===== design/ckrk_pkg.sv =====
// Shared types, constants and coefficient tables for the Cash-Karp stage combiner.
// Used by ckrk_mul, ckrk_div and cash_karp_rk45_stage_combiner; depends on nothing.
package ckrk_pkg;

    localparam int NUM_VARS   = 64;
    localparam int VAR_ADDR_W = $clog2(NUM_VARS);
    localparam int OPD_W      = 33;           // multiplier operand, signed
    localparam int PROD_W     = 2 * OPD_W;    // multiplier product, signed
    localparam int ACC_W      = PROD_W + 1;   // accumulator, signed
    localparam int TOL_W      = 49;           // tolerance, unsigned
    localparam int DIVD_W     = 49;           // dividend: 33-bit difference << 16
    localparam int CNT_W      = $clog2(DIVD_W + 1);

    localparam logic [30:0] RATIO_MAX    = 31'h7FFF_FFFF;
    localparam logic [30:0] ACCEPT_LIMIT = 31'd72089;

    // Configuration register indexes
    localparam logic [2:0] REG_STEP_INTERVAL = 3'd0;
    localparam logic [2:0] REG_REL_TOL       = 3'd1;
    localparam logic [2:0] REG_ABS_FACTOR    = 3'd2;
    localparam logic [2:0] REG_STATE_WEIGHT  = 3'd3;
    localparam logic [2:0] REG_SLOPE_WEIGHT  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_ISSUE, S_EXEC, S_DIVW, S_WRITE
    } state_t;

    typedef enum logic [3:0] {
        OP_MAC, OP_ROUND, OP_TRIAL, OP_ADDF, OP_ADDO,
        OP_INNER1, OP_INNER2, OP_ROUNDI, OP_TOL1, OP_TOL2, OP_DIV, OP_DONE
    } op_t;

    typedef struct packed {
        logic [4:0][31:0]   k;
        logic signed [31:0] fsum;
        logic signed [31:0] osum;
    } slope_row_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [TOL_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_rsp_t;

    // Micro-op program: slope terms, round, scale by h, order sums; stage 6 does the error.
    function automatic op_t op_at(input logic [2:0] stage, input logic [3:0] pc);
        logic has_f;
        logic has_o;
        logic [3:0] rel;
        op_t op;
        has_f = (stage == 3'd1) || (stage == 3'd3) || (stage == 3'd4);
        has_o = has_f || (stage == 3'd5);
        rel   = pc - {1'b0, stage};
        op    = OP_DONE;
        if (stage == 3'd6) begin
            case (pc)
                4'd0:    op = OP_ADDF;
                4'd1:    op = OP_ADDO;
                4'd2:    op = OP_INNER1;
                4'd3:    op = OP_INNER2;
                4'd4:    op = OP_ROUNDI;
                4'd5:    op = OP_TOL1;
                4'd6:    op = OP_TOL2;
                4'd7:    op = OP_DIV;
                default: op = OP_DONE;
            endcase
        end else if (pc < {1'b0, stage}) begin
            op = OP_MAC;
        end else begin
            case (rel)
                4'd0:    op = OP_ROUND;
                4'd1:    op = OP_TRIAL;
                4'd2:    op = has_f ? OP_ADDF : (has_o ? OP_ADDO : OP_DONE);
                4'd3:    op = (has_f && has_o) ? OP_ADDO : OP_DONE;
                default: op = OP_DONE;
            endcase
        end
        return op;
    endfunction

    // a_ij with 24 fraction bits; term j of stage's trial sum (last term is the new slope)
    function automatic logic signed [OPD_W-1:0] coef_trial(input logic [2:0] stage,
                                                           input logic [2:0] j);
        logic signed [OPD_W-1:0] c;
        c = '0;
        case (stage)
            3'd1: c = 33'sd3355443;
            3'd2: begin
                case (j)
                    3'd0:    c = 33'sd1258291;
                    default: c = 33'sd3774874;
                endcase
            end
            3'd3: begin
                case (j)
                    3'd0:    c = 33'sd5033165;
                    3'd1:    c = -33'sd15099494;
                    default: c = 33'sd20132659;
                endcase
            end
            3'd4: begin
                case (j)
                    3'd0:    c = -33'sd3417581;
                    3'd1:    c = 33'sd41943040;
                    3'd2:    c = -33'sd43496486;
                    default: c = 33'sd21748243;
                endcase
            end
            3'd5: begin
                case (j)
                    3'd0:    c = 33'sd494857;
                    3'd1:    c = 33'sd5734400;
                    3'd2:    c = 33'sd697837;
                    3'd3:    c = 33'sd6716681;
                    default: c = 33'sd1036288;
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [OPD_W-1:0] coef_fifth(input logic [2:0] stage);
        logic signed [OPD_W-1:0] c;
        case (stage)
            3'd1:    c = 33'sd1642214;
            3'd3:    c = 33'sd6754113;
            3'd4:    c = 33'sd3530559;
            3'd6:    c = 33'sd4850330;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [OPD_W-1:0] coef_fourth(input logic [2:0] stage);
        logic signed [OPD_W-1:0] c;
        case (stage)
            3'd1:    c = 33'sd1714252;
            3'd3:    c = 33'sd6440906;
            3'd4:    c = 33'sd4103585;
            3'd5:    c = 33'sd324169;
            3'd6:    c = 33'sd4194304;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [30:0] time_next(input logic [2:0] stage);
        logic [30:0] t;
        case (stage)
            3'd1:    t = 31'd13107;
            3'd2:    t = 31'd19661;
            3'd3:    t = 31'd39322;
            3'd4:    t = 31'd65536;
            3'd5:    t = 31'd57344;
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > 67'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -67'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/ckrk_mul.sv =====
// Shared signed 33 x 33 multiplier with a registered product.
// Depends on ckrk_pkg for operand and product widths.
module ckrk_mul (
    input  logic                                   aclk,
    input  logic signed [ckrk_pkg::OPD_W-1:0]      mul_a,
    input  logic signed [ckrk_pkg::OPD_W-1:0]      mul_b,
    output logic signed [ckrk_pkg::PROD_W-1:0]     prod
);

    logic signed [ckrk_pkg::PROD_W-1:0] prod_reg;
    logic signed [ckrk_pkg::PROD_W-1:0] prod_next;

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== design/ckrk_div.sv =====
// Restoring divider, one quotient bit a cycle, for the scaled error ratio.
// Depends on ckrk_pkg for the request and response structs.
module ckrk_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  ckrk_pkg::div_req_t  req,
    output ckrk_pkg::div_rsp_t  rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [ckrk_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ckrk_pkg::TOL_W-1:0]    rem_reg, rem_next;
    logic [ckrk_pkg::DIVD_W-1:0]   quo_reg, quo_next;
    logic [ckrk_pkg::TOL_W-1:0]    dsr_reg, dsr_next;
    logic [ckrk_pkg::TOL_W:0]      shifted;
    logic [ckrk_pkg::TOL_W:0]      diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[ckrk_pkg::DIVD_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = ckrk_pkg::CNT_W'(ckrk_pkg::DIVD_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            // subtract where the shifted remainder covers the divisor
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = diff[ckrk_pkg::TOL_W-1:0];
                quo_next = {quo_reg[ckrk_pkg::DIVD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[ckrk_pkg::TOL_W-1:0];
                quo_next = {quo_reg[ckrk_pkg::DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ckrk_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== design/cash_karp_rk45_stage_combiner.sv =====
// Cash-Karp RK4(5) stage combiner: sequencer, slope memory and register port.
// Depends on ckrk_pkg, ckrk_mul and ckrk_div.
//
// Usage:
//   Input items arrive on s_*: s_tuser carries the stage (1..6), s_tlast marks the
//   last variable of a stage, s_tdata the index, start value and slope. Each item
//   gives one result on m_*: trial value and next time offset for stages 1..5,
//   velocity, running error ratio and accept flag at stage 6; m_tlast repeats
//   s_tlast. Items with stage 0 or 7 are taken and dropped without a result.
//   One item is worked at a time through a single shared multiplier: every
//   micro-op selects its operands, registers the product, then updates. At
//   stage 6 the sequencer waits on the divider that forms the error ratio.
//   s_tready is high only while the block waits for an item; a finished result
//   sits in the output register, so the next item is taken while it waits.
//   If the receiver stalls, the following result is held back until the output
//   register frees. Reset clears the sequencer, the running maximum error and
//   the registers to their defaults; stored slopes hold nothing until written.
//   Registers sit on the APB port at byte addresses 0, 4, 8, 12 and 16.
module cash_karp_rk45_stage_combiner (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // var_index[5:0], start_value[37:6], slope[69:38]
    input  logic [2:0]   s_tuser,   // stage[2:0]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // out_index[5:0], trial_value[37:6],
                                    // next_time_offset[68:38], final_velocity[100:69],
                                    // error_ratio[131:101], accepted[132]
    output logic [2:0]   m_tuser,   // out_stage[2:0]
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = ckrk_pkg::ACC_W;

    ckrk_pkg::state_t state_reg, state_next;
    ckrk_pkg::op_t    op;

    logic [3:0]                  pc_reg;
    logic [2:0]                  stage_reg;
    logic [5:0]                  idx_reg;
    logic signed [31:0]          x_reg;
    logic signed [31:0]          k_reg;
    logic                        last_reg;
    ckrk_pkg::slope_row_t        row_reg;
    ckrk_pkg::slope_row_t        row_wr;
    ckrk_pkg::slope_row_t        mem [ckrk_pkg::NUM_VARS];
    logic signed [AW-1:0]        acc_reg;
    logic signed [31:0]          s_reg;
    logic signed [31:0]          trial_reg;
    logic [31:0]                 inner_reg;
    logic [ckrk_pkg::TOL_W-1:0]  tol_reg;
    logic [30:0]                 ratio_out_reg;
    logic                        accepted_reg;
    logic [30:0]                 max_err_reg;

    logic [30:0] step_interval_reg, rel_tol_reg, abs_factor_reg;
    logic [30:0] state_weight_reg, slope_weight_reg;

    logic         m_valid_reg;
    logic [2:0]   out_stage_reg;
    logic [5:0]   out_index_reg;
    logic [31:0]  out_trial_reg;
    logic [30:0]  out_time_reg;
    logic [31:0]  out_vel_reg;
    logic [30:0]  out_ratio_reg;
    logic         out_acc_reg;
    logic         out_last_reg;

    logic                               s_accept;
    logic                               item_ok;
    logic                               out_free;
    logic                               mem_we;
    logic                               div_wait_done;
    logic signed [ckrk_pkg::OPD_W-1:0]  mul_a, mul_b;
    logic signed [ckrk_pkg::PROD_W-1:0] prod;
    logic signed [AW-1:0]               prod_ext;
    logic signed [AW-1:0]               rnd24, rnd16;
    logic signed [AW-1:0]               acc_rnd24, acc_rnd16;
    logic signed [32:0]                 x_ext, x_abs, f_ext, f_abs;
    logic signed [32:0]                 d_ext;
    logic [32:0]                        diff_abs;
    logic                               tol_zero;
    logic [30:0]                        ratio_c, newmax_c;
    logic [2:0]                         kslot;
    logic signed [31:0]                 f_base, o_base;
    ckrk_pkg::div_req_t                 div_req;
    ckrk_pkg::div_rsp_t                 div_rsp;

    ckrk_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    ckrk_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign op       = ckrk_pkg::op_at(stage_reg, pc_reg);
    assign s_accept = s_tvalid && s_tready;
    assign item_ok  = (s_tuser != 3'd0) && (s_tuser != 3'd7)
                      && (32'(s_tdata[5:0]) < 32'(ckrk_pkg::NUM_VARS));
    assign out_free = !m_valid_reg || m_tready;

    // ---------------- arithmetic helpers ----------------
    always_comb begin
        prod_ext  = AW'(prod);
        rnd24     = (prod_ext + AW'(64'sd8388608)) >>> 24;
        rnd16     = (prod_ext + AW'(64'sd32768)) >>> 16;
        acc_rnd24 = (acc_reg + AW'(64'sd8388608)) >>> 24;
        acc_rnd16 = (acc_reg + AW'(64'sd32768)) >>> 16;
        x_ext     = {x_reg[31], x_reg};
        x_abs     = x_ext[32] ? -x_ext : x_ext;
        f_ext     = {row_reg.fsum[31], row_reg.fsum};
        f_abs     = f_ext[32] ? -f_ext : f_ext;
        d_ext     = {row_reg.fsum[31], row_reg.fsum} - {row_reg.osum[31], row_reg.osum};
        diff_abs  = d_ext[32] ? 33'(-d_ext) : 33'(d_ext);
        tol_zero  = (tol_reg == '0);
        f_base    = (stage_reg == 3'd1) ? 32'sd0 : row_reg.fsum;
        o_base    = (stage_reg == 3'd1) ? 32'sd0 : row_reg.osum;
        kslot     = pc_reg[2:0];
        if (tol_zero) begin
            ratio_c = (diff_abs == '0) ? 31'd0 : ckrk_pkg::RATIO_MAX;
        end else if (div_rsp.quotient > ckrk_pkg::DIVD_W'(ckrk_pkg::RATIO_MAX)) begin
            ratio_c = ckrk_pkg::RATIO_MAX;
        end else begin
            ratio_c = div_rsp.quotient[30:0];
        end
        newmax_c = (ratio_c > max_err_reg) ? ratio_c : max_err_reg;
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            ckrk_pkg::OP_MAC: begin
                if ({1'b0, kslot} == ({1'b0, stage_reg} - 4'd1)) begin
                    mul_a = {k_reg[31], k_reg};
                end else begin
                    mul_a = {row_reg.k[kslot][31], row_reg.k[kslot]};
                end
                mul_b = ckrk_pkg::coef_trial(stage_reg, kslot);
            end
            ckrk_pkg::OP_TRIAL: begin
                mul_a = {s_reg[31], s_reg};
                mul_b = {2'b00, step_interval_reg};
            end
            ckrk_pkg::OP_ADDF: begin
                mul_a = {k_reg[31], k_reg};
                mul_b = ckrk_pkg::coef_fifth(stage_reg);
            end
            ckrk_pkg::OP_ADDO: begin
                mul_a = {k_reg[31], k_reg};
                mul_b = ckrk_pkg::coef_fourth(stage_reg);
            end
            ckrk_pkg::OP_INNER1: begin
                mul_a = x_abs;
                mul_b = {2'b00, state_weight_reg};
            end
            ckrk_pkg::OP_INNER2: begin
                mul_a = f_abs;
                mul_b = {2'b00, slope_weight_reg};
            end
            ckrk_pkg::OP_TOL1: begin
                mul_a = {1'b0, inner_reg};
                mul_b = {2'b00, rel_tol_reg};
            end
            ckrk_pkg::OP_TOL2: begin
                mul_a = {2'b00, abs_factor_reg};
                mul_b = {2'b00, rel_tol_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- sequencer: next state ----------------
    assign div_wait_done = tol_zero || div_rsp.done;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ckrk_pkg::S_IDLE: begin
                if (s_accept && item_ok) begin
                    state_next = ckrk_pkg::S_READ;
                end
            end
            ckrk_pkg::S_READ: state_next = ckrk_pkg::S_ISSUE;
            ckrk_pkg::S_ISSUE: begin
                if (op == ckrk_pkg::OP_DONE) begin
                    state_next = ckrk_pkg::S_WRITE;
                end else if (op == ckrk_pkg::OP_DIV) begin
                    state_next = ckrk_pkg::S_DIVW;
                end else begin
                    state_next = ckrk_pkg::S_EXEC;
                end
            end
            ckrk_pkg::S_EXEC: state_next = ckrk_pkg::S_ISSUE;
            ckrk_pkg::S_DIVW: begin
                if (div_wait_done) begin
                    state_next = ckrk_pkg::S_ISSUE;
                end
            end
            ckrk_pkg::S_WRITE: begin
                if (out_free) begin
                    state_next = ckrk_pkg::S_IDLE;
                end
            end
            default: state_next = ckrk_pkg::S_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_tready         = 1'b0;
        mem_we           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {diff_abs, 16'd0};
        div_req.divisor  = tol_reg;
        unique case (state_reg)
            ckrk_pkg::S_IDLE:  s_tready = 1'b1;
            ckrk_pkg::S_ISSUE: div_req.start = (op == ckrk_pkg::OP_DIV) && !tol_zero;
            ckrk_pkg::S_WRITE: mem_we = out_free;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // slope row to write back: store this stage's slope in its slot
    always_comb begin
        row_wr = row_reg;
        if (stage_reg != 3'd6) begin
            row_wr.k[stage_reg - 3'd1] = k_reg;
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ckrk_pkg::S_IDLE;
            pc_reg            <= '0;
            max_err_reg       <= '0;
            m_valid_reg       <= 1'b0;
            step_interval_reg <= 31'd65536;
            rel_tol_reg       <= 31'd66;
            abs_factor_reg    <= 31'd65536;
            state_weight_reg  <= 31'd65536;
            slope_weight_reg  <= 31'd0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ckrk_pkg::S_READ) begin
                pc_reg <= '0;
            end else if (state_reg == ckrk_pkg::S_EXEC
                         || (state_reg == ckrk_pkg::S_DIVW && div_wait_done)) begin
                pc_reg <= pc_reg + 4'd1;
            end
            if (state_reg == ckrk_pkg::S_DIVW && div_wait_done) begin
                max_err_reg <= last_reg ? 31'd0 : newmax_c;
            end
            if (state_reg == ckrk_pkg::S_WRITE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (psel && penable && pwrite) begin
                unique case (paddr[4:2])
                    ckrk_pkg::REG_STEP_INTERVAL: step_interval_reg <= pwdata[30:0];
                    ckrk_pkg::REG_REL_TOL:       rel_tol_reg       <= pwdata[30:0];
                    ckrk_pkg::REG_ABS_FACTOR:    abs_factor_reg    <= pwdata[30:0];
                    ckrk_pkg::REG_STATE_WEIGHT:  state_weight_reg  <= pwdata[30:0];
                    ckrk_pkg::REG_SLOPE_WEIGHT:  slope_weight_reg  <= pwdata[30:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------- datapath, slope memory and output register ----------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stage_reg <= s_tuser;
            idx_reg   <= s_tdata[5:0];
            x_reg     <= s_tdata[37:6];
            k_reg     <= s_tdata[69:38];
            last_reg  <= s_tlast;
        end
        if (state_reg == ckrk_pkg::S_READ) begin
            row_reg <= mem[idx_reg[ckrk_pkg::VAR_ADDR_W-1:0]];
            acc_reg <= '0;
        end
        if (state_reg == ckrk_pkg::S_EXEC) begin
            case (op)
                ckrk_pkg::OP_MAC:    acc_reg <= acc_reg + prod_ext;
                ckrk_pkg::OP_ROUND:  s_reg <= ckrk_pkg::sat32(acc_rnd24);
                ckrk_pkg::OP_TRIAL:  trial_reg <= ckrk_pkg::sat32(AW'(x_reg) + rnd16);
                ckrk_pkg::OP_ADDF:   row_reg.fsum <= ckrk_pkg::sat32(AW'(f_base) + rnd24);
                ckrk_pkg::OP_ADDO:   row_reg.osum <= ckrk_pkg::sat32(AW'(o_base) + rnd24);
                ckrk_pkg::OP_INNER1: acc_reg <= prod_ext;
                ckrk_pkg::OP_INNER2: acc_reg <= acc_reg + prod_ext;
                ckrk_pkg::OP_ROUNDI: begin
                    // clamp the rounded tolerance base to 32 bits
                    if (acc_rnd16 > AW'(64'sd4294967295)) begin
                        inner_reg <= 32'hFFFF_FFFF;
                    end else begin
                        inner_reg <= acc_rnd16[31:0];
                    end
                end
                ckrk_pkg::OP_TOL1:   tol_reg <= rnd16[ckrk_pkg::TOL_W-1:0];
                ckrk_pkg::OP_TOL2:   tol_reg <= tol_reg + rnd16[ckrk_pkg::TOL_W-1:0];
                default: begin
                end
            endcase
        end
        if (state_reg == ckrk_pkg::S_DIVW && div_wait_done) begin
            ratio_out_reg <= newmax_c;
            accepted_reg  <= last_reg && (newmax_c <= ckrk_pkg::ACCEPT_LIMIT);
        end
        if (mem_we) begin
            mem[idx_reg[ckrk_pkg::VAR_ADDR_W-1:0]] <= row_wr;
            out_stage_reg <= stage_reg;
            out_index_reg <= idx_reg;
            out_time_reg  <= ckrk_pkg::time_next(stage_reg);
            out_last_reg  <= last_reg;
            if (stage_reg == 3'd6) begin
                out_trial_reg <= x_reg;
                out_vel_reg   <= row_reg.fsum;
                out_ratio_reg <= ratio_out_reg;
                out_acc_reg   <= accepted_reg;
            end else begin
                out_trial_reg <= trial_reg;
                out_vel_reg   <= '0;
                out_ratio_reg <= '0;
                out_acc_reg   <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_stage_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'd0, out_acc_reg, out_ratio_reg, out_vel_reg, out_time_reg,
                       out_trial_reg, out_index_reg};

    // register read-back
    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            ckrk_pkg::REG_STEP_INTERVAL: prdata = {1'b0, step_interval_reg};
            ckrk_pkg::REG_REL_TOL:       prdata = {1'b0, rel_tol_reg};
            ckrk_pkg::REG_ABS_FACTOR:    prdata = {1'b0, abs_factor_reg};
            ckrk_pkg::REG_STATE_WEIGHT:  prdata = {1'b0, state_weight_reg};
            ckrk_pkg::REG_SLOPE_WEIGHT:  prdata = {1'b0, slope_weight_reg};
            default:                     prdata = '0;
        endcase
    end

    assign pready = 1'b1;

endmodule

// ===== tb/cash_karp_rk45_stage_combiner_checker.sv =====
// Checker for the Cash-Karp stage combiner: watches both streams and the APB port.
// Predicts each result in Q16.16 and compares it with the block's output; uses ckrk_pkg.
`timescale 1ns / 1ps

module cash_karp_rk45_stage_combiner_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [71:0]  s_tdata,   // var_index[5:0], start_value[37:6], slope[69:38]
    input  logic [2:0]   s_tuser,   // stage[2:0]
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,   // out_index[5:0], trial_value[37:6],
                                    // next_time_offset[68:38], final_velocity[100:69],
                                    // error_ratio[131:101], accepted[132]
    input  logic [2:0]   m_tuser,   // out_stage[2:0]
    input  logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic         pready,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output int           fail_count,
    output int           pending
);

    localparam longint unsigned ERR_SAT = 64'h7FFF_FFFF;
    localparam longint unsigned INNER_SAT = 64'hFFFF_FFFF;

    typedef struct {
        logic [2:0]  stg;
        logic [5:0]  idx;
        logic [31:0] trial;
        logic [30:0] tofs;
        logic [31:0] vel;
        logic [30:0] ratio;
        logic        acc;
        logic        eos;
    } stage_result_t;

    stage_result_t   result_q[$];
    longint          k_mem[1:5][ckrk_pkg::NUM_VARS];
    longint          fifth_sum[ckrk_pkg::NUM_VARS];
    longint          fourth_sum[ckrk_pkg::NUM_VARS];
    longint unsigned peak_err;
    longint unsigned h_step, rel_tol, abs_fac, y_wt, v_wt;

    function automatic longint rnd_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint trial_point(longint x, longint acc);
        longint s;
        s = clip32(rnd_shift(acc, 24));
        return clip32(x + rnd_shift(s * longint'(h_step), 16));
    endfunction

    function automatic longint add_weighted(longint sum, longint k, longint c);
        return clip32(sum + rnd_shift(k * c, 24));
    endfunction

    // Advance the slope store and order sums for one item, return its result.
    function automatic stage_result_t combine_stage(logic [2:0] stg, logic [5:0] idx,
                                                    longint x, longint k, logic last);
        stage_result_t r;
        longint acc;
        longint unsigned inner, tol, diff, ratio;
        r.stg = stg; r.idx = idx; r.trial = x[31:0]; r.vel = '0;
        r.ratio = '0; r.acc = 1'b0; r.eos = last; r.tofs = '0;
        case (stg)
            3'd1: begin
                k_mem[1][idx] = k;
                r.trial = trial_point(x, k * 3355443);
                fifth_sum[idx] = clip32(rnd_shift(k * 1642214, 24));
                fourth_sum[idx] = clip32(rnd_shift(k * 1714252, 24));
                r.tofs = 31'd13107;
            end
            3'd2: begin
                k_mem[2][idx] = k;
                acc = k_mem[1][idx] * 1258291 + k * 3774874;
                r.trial = trial_point(x, acc);
                r.tofs = 31'd19661;
            end
            3'd3: begin
                k_mem[3][idx] = k;
                acc = k_mem[1][idx] * 5033165 - k_mem[2][idx] * 15099494 + k * 20132659;
                r.trial = trial_point(x, acc);
                fifth_sum[idx] = add_weighted(fifth_sum[idx], k, 6754113);
                fourth_sum[idx] = add_weighted(fourth_sum[idx], k, 6440906);
                r.tofs = 31'd39322;
            end
            3'd4: begin
                k_mem[4][idx] = k;
                acc = k_mem[2][idx] * 41943040 - k_mem[1][idx] * 3417581
                    - k_mem[3][idx] * 43496486 + k * 21748243;
                r.trial = trial_point(x, acc);
                fifth_sum[idx] = add_weighted(fifth_sum[idx], k, 3530559);
                fourth_sum[idx] = add_weighted(fourth_sum[idx], k, 4103585);
                r.tofs = 31'd65536;
            end
            3'd5: begin
                k_mem[5][idx] = k;
                acc = k_mem[1][idx] * 494857 + k_mem[2][idx] * 5734400
                    + k_mem[3][idx] * 697837 + k_mem[4][idx] * 6716681 + k * 1036288;
                r.trial = trial_point(x, acc);
                fourth_sum[idx] = add_weighted(fourth_sum[idx], k, 324169);
                r.tofs = 31'd57344;
            end
            default: begin
                fifth_sum[idx] = add_weighted(fifth_sum[idx], k, 4850330);
                fourth_sum[idx] = add_weighted(fourth_sum[idx], k, 4194304);
                r.vel = fifth_sum[idx][31:0];
                inner = y_wt * mag(x) + v_wt * mag(fifth_sum[idx]);
                inner = (inner + 32768) >> 16;
                if (inner > INNER_SAT) inner = INNER_SAT;
                tol = ((rel_tol * inner + 32768) >> 16) + ((rel_tol * abs_fac + 32768) >> 16);
                diff = mag(fifth_sum[idx] - fourth_sum[idx]);
                if (tol == 0) ratio = (diff == 0) ? 0 : ERR_SAT;
                else ratio = (diff << 16) / tol;
                if (ratio > ERR_SAT) ratio = ERR_SAT;
                if (ratio > peak_err) peak_err = ratio;
                r.ratio = peak_err[30:0];
                if (last) begin
                    r.acc = (peak_err <= longint'(ckrk_pkg::ACCEPT_LIMIT));
                    peak_err = 0;
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        stage_result_t got, want;
        if (!aresetn) begin
            result_q.delete();
            peak_err = 0;
            h_step = 65536; rel_tol = 66; abs_fac = 65536; y_wt = 65536; v_wt = 0;
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    ckrk_pkg::REG_STEP_INTERVAL: h_step = pwdata[30:0];
                    ckrk_pkg::REG_REL_TOL:       rel_tol = pwdata[30:0];
                    ckrk_pkg::REG_ABS_FACTOR:    abs_fac = pwdata[30:0];
                    ckrk_pkg::REG_STATE_WEIGHT:  y_wt = pwdata[30:0];
                    ckrk_pkg::REG_SLOPE_WEIGHT:  v_wt = pwdata[30:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.stg = m_tuser; got.idx = m_tdata[5:0]; got.trial = m_tdata[37:6];
                got.tofs = m_tdata[68:38]; got.vel = m_tdata[100:69];
                got.ratio = m_tdata[131:101]; got.acc = m_tdata[132]; got.eos = m_tlast;
                if (result_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected item: stage %0d index %0d", got.stg, got.idx);
                end else begin
                    want = result_q.pop_front();
                    if (got.stg != want.stg || got.idx != want.idx || got.trial != want.trial
                        || got.tofs != want.tofs || got.vel != want.vel
                        || got.ratio != want.ratio || got.acc != want.acc
                        || got.eos != want.eos) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: exp %p act %p", want, got);
                    end
                end
            end
            // drop bad stages without a result
            if (s_tvalid && s_tready && s_tuser >= 3'd1 && s_tuser <= 3'd6)
                result_q.push_back(combine_stage(s_tuser, s_tdata[5:0],
                    longint'($signed(s_tdata[37:6])), longint'($signed(s_tdata[69:38])),
                    s_tlast));
        end
        pending <= result_q.size();
    end

endmodule

// ===== tb/tb_cash_karp_rk45_stage_combiner.sv =====
// Testbench top for cash_karp_rk45_stage_combiner: clock, reset, stimulus and verdict.
// Depends on ckrk_pkg, the block and cash_karp_rk45_stage_combiner_checker.
`timescale 1ns / 1ps

module tb_cash_karp_rk45_stage_combiner;

    localparam logic [2:0] STG_NONE  = 3'd0;
    localparam logic [2:0] STG_FIRST = 3'd1;
    localparam logic [2:0] STG_LAST  = 3'd6;
    localparam logic [2:0] STG_SPARE = 3'd7;
    localparam int ITEM_TARGET = 1150;
    localparam int STALL_LIMIT = 5000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0, s_tready, s_tlast = 1'b0;
    logic [71:0]  s_tdata = '0;   // var_index[5:0], start_value[37:6], slope[69:38]
    logic [2:0]   s_tuser = '0;   // stage[2:0]
    logic         m_tvalid, m_tready = 1'b0, m_tlast;
    logic [135:0] m_tdata;        // out_index[5:0], trial_value[37:6],
                                  // next_time_offset[68:38], final_velocity[100:69],
                                  // error_ratio[131:101], accepted[132]
    logic [2:0]   m_tuser;        // out_stage[2:0]
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0, prdata;
    int           fail_count, pending, stall_cnt = 0, item_cnt = 0;
    bit           no_idle = 1'b0;

    cash_karp_rk45_stage_combiner u_top (.*);

    cash_karp_rk45_stage_combiner_checker u_chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .fail_count, .pending
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("cash_karp_rk45_stage_combiner regression: fail");
            $finish;
        end
    end

    // Result side: unless no_idle is set, drop m_tready at random before each item.
    initial begin
        int g;
        forever begin
            g = no_idle ? 0 : $urandom_range(0, 9);
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (!m_tvalid);
            @(posedge aclk);
        end
    end

    task automatic send_item(logic [2:0] stg, logic [5:0] idx, logic [31:0] x,
                             logic [31:0] k, logic last);
        int g;
        g = no_idle ? 0 : $urandom_range(0, 9);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= stg;
        s_tlast  <= last;
        s_tdata  <= {2'b00, k, x, idx};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        if (stg >= STG_FIRST && stg <= STG_LAST) item_cnt++;
    endtask

    task automatic apb_write(logic [2:0] reg_idx, logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {reg_idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Hold off until every result is back and dropped items have drained.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_setting(logic [31:0] dflt);
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'h7FFF_FFFF;
            2: return dflt;
            3: return $urandom_range(0, 32'h0004_0000);
            4: return $urandom_range(32'h0000_0100, 32'h0100_0000);
            default: return $urandom() & 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_value(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'h0;
        endcase
    endfunction

    // One integration step over nv distinct variables, stopped after upto stages.
    task automatic run_step(int nv, int upto, bit mark_last);
        logic [5:0]  idx[8];
        logic [31:0] xv[8], base[8];
        bit          used[64];
        int          mode, xmode;
        logic [31:0] k;
        for (int i = 0; i < 64; i++) used[i] = 1'b0;
        mode  = $urandom_range(0, 5);
        xmode = $urandom_range(0, 4);
        for (int v = 0; v < nv; v++) begin
            do idx[v] = 6'($urandom_range(0, 63)); while (used[idx[v]]);
            used[idx[v]] = 1'b1;
            xv[v] = pick_value(xmode > 2 ? 0 : xmode);
            base[v] = pick_value(mode > 3 ? 1 : mode);
        end
        for (int s = STG_FIRST; s <= upto; s++)
            for (int v = 0; v < nv; v++) begin
                // consistent slopes give small error estimates and accepted steps
                if (mode == 4) k = base[v] + $urandom_range(0, 64) - 32;
                else if (mode == 5) k = base[v];
                else k = pick_value(mode);
                send_item(s[2:0], idx[v], xv[v], k, mark_last && (v == nv - 1));
                if ($urandom_range(0, 19) == 0)
                    send_item(($urandom_range(0, 1) != 0) ? STG_SPARE : STG_NONE,
                              6'($urandom()), $urandom(), $urandom(),
                              1'($urandom_range(0, 1)));
            end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes at index 0 and 63, dropped stages, then zero slopes at index 7
        for (int s = STG_FIRST; s <= STG_LAST; s++) begin
            send_item(s[2:0], 6'd0, 32'h7FFF_FFFF,
                      (s % 2 != 0) ? 32'h7FFF_FFFF : 32'h8000_0000, 1'b0);
            send_item(s[2:0], 6'd63, 32'h8000_0000,
                      (s % 2 != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF, 1'b1);
        end
        send_item(STG_NONE, 6'd5, $urandom(), $urandom(), 1'b1);
        send_item(STG_SPARE, 6'd63, $urandom(), $urandom(), 1'b0);
        for (int s = STG_FIRST; s <= STG_LAST; s++)
            send_item(s[2:0], 6'd7, 32'h0001_0000, 32'h0, 1'b1);
        drain_block();

        while (item_cnt < ITEM_TARGET) begin
            apb_write(ckrk_pkg::REG_STEP_INTERVAL, pick_setting(32'h0001_0000));
            apb_write(ckrk_pkg::REG_REL_TOL, pick_setting(32'd66));
            apb_write(ckrk_pkg::REG_ABS_FACTOR, pick_setting(32'h0001_0000));
            apb_write(ckrk_pkg::REG_STATE_WEIGHT, pick_setting(32'h0001_0000));
            apb_write(ckrk_pkg::REG_SLOPE_WEIGHT, pick_setting(32'h0));
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 4 && item_cnt < ITEM_TARGET; n++) begin
                if ($urandom_range(0, 9) == 0)
                    run_step($urandom_range(1, 4), $urandom_range(1, 5), 1'b1);
                else
                    run_step($urandom_range(1, 8), STG_LAST,
                             $urandom_range(0, 9) != 0);
            end
            drain_block();
        end

        no_idle = 1'b0;
        drain_block();
        if (fail_count == 0)
            $display("cash_karp_rk45_stage_combiner regression: pass");
        else
            $display("cash_karp_rk45_stage_combiner regression: fail");
        $finish;
    end

endmodule
